@@ sv/ttb_pkg.sv @@
// Shared types and constants of the triangle tangent and bitangent block.
`default_nettype none
package ttb_pkg;

    localparam int unsigned CoordW    = 32;
    localparam int unsigned NormW     = 16;
    localparam int unsigned OutW      = 16;
    localparam int unsigned DeltaW    = CoordW + 1;
    localparam int unsigned FifoDepth = 2;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [NormW-1:0]  norm_t;
    typedef logic signed [OutW-1:0]   outv_t;
    typedef logic signed [DeltaW-1:0] delta_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        coord_t tex_u;
        coord_t tex_v;
        norm_t  norm_x;
        norm_t  norm_y;
        norm_t  norm_z;
    } vertex_t;

    typedef struct packed {
        outv_t tangent_x;
        outv_t tangent_y;
        outv_t tangent_z;
        outv_t bitangent_x;
        outv_t bitangent_y;
        outv_t bitangent_z;
        logic  degenerate;
    } result_t;

    typedef struct packed {
        delta_t [2:0] e1;
        delta_t [2:0] e2;
        delta_t       d1u;
        delta_t       d1v;
        delta_t       d2u;
        delta_t       d2v;
        norm_t  [2:0] n;
    } job_t;

endpackage
`default_nettype wire

@@ sv/ttb_stream_if.sv @@
// Valid and ready stream channel carrying one payload beat.
`default_nettype none
interface ttb_stream_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/ttb_front.sv @@
// Vertex intake: holds the first two vertices and forms the triangle job.
`default_nettype none
module ttb_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ttb_stream_if.sink      vtx,
    output ttb_pkg::job_t   push_job,
    output logic            push_valid,
    input  wire logic       push_ready
);

    logic [1:0]     slot_reg;
    ttb_pkg::coord_t p1_reg [3];
    ttb_pkg::coord_t p2_reg [3];
    ttb_pkg::coord_t uv1_reg [2];
    ttb_pkg::coord_t uv2_reg [2];
    ttb_pkg::norm_t  n1_reg [3];
    ttb_pkg::coord_t p3 [3];
    logic            accept;

    assign p3[0] = vtx.data.pos_x;
    assign p3[1] = vtx.data.pos_y;
    assign p3[2] = vtx.data.pos_z;

    assign vtx.ready  = (slot_reg != 2'd2) || push_ready;
    assign push_valid = vtx.valid && (slot_reg == 2'd2);
    assign accept     = vtx.valid && vtx.ready;

    function automatic ttb_pkg::delta_t sub33(ttb_pkg::coord_t a, ttb_pkg::coord_t b);
        return $signed({a[ttb_pkg::CoordW-1], a}) - $signed({b[ttb_pkg::CoordW-1], b});
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            push_job.e1[i] = sub33(p2_reg[i], p1_reg[i]);
            push_job.e2[i] = sub33(p3[i], p1_reg[i]);
            push_job.n[i]  = n1_reg[i];
        end
        push_job.d1u = sub33(uv2_reg[0], uv1_reg[0]);
        push_job.d1v = sub33(uv2_reg[1], uv1_reg[1]);
        push_job.d2u = sub33(vtx.data.tex_u, uv1_reg[0]);
        push_job.d2v = sub33(vtx.data.tex_v, uv1_reg[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
        end
        else if (accept)
        begin
            unique case (slot_reg)
                2'd1:    slot_reg <= 2'd2;
                2'd2:    slot_reg <= 2'd0;
                default: slot_reg <= 2'd1;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && slot_reg == 2'd1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p2_reg[i] <= p3[i];
            end
            uv2_reg[0] <= vtx.data.tex_u;
            uv2_reg[1] <= vtx.data.tex_v;
        end
        else if (accept && slot_reg != 2'd2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= p3[i];
            end
            n1_reg[0]  <= vtx.data.norm_x;
            n1_reg[1]  <= vtx.data.norm_y;
            n1_reg[2]  <= vtx.data.norm_z;
            uv1_reg[0] <= vtx.data.tex_u;
            uv1_reg[1] <= vtx.data.tex_v;
        end
    end

endmodule
`default_nettype wire

@@ sv/ttb_fifo.sv @@
// Short job queue between the vertex intake and the vector sequencer.
`default_nettype none
module ttb_fifo #(
    parameter int unsigned DEPTH = ttb_pkg::FifoDepth
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ttb_pkg::job_t  push_job,
    input  wire logic           push_valid,
    output logic                push_ready,
    output ttb_pkg::job_t       pop_job,
    output logic                pop_valid,
    input  wire logic           pop_ready
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    ttb_pkg::job_t mem [DEPTH];
    logic [PtrW-1:0] wptr_reg;
    logic [PtrW-1:0] rptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = count_reg != CntW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = mem[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PtrW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PtrW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

@@ sv/ttb_back.sv @@
// Vector sequencer: products, normalization, square root, division and fallback crosses.
`default_nettype none
module ttb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ttb_pkg::job_t  job,
    input  wire logic           job_valid,
    output logic                job_ready,
    ttb_stream_if.source        res
);

    localparam int unsigned WideW = 67;
    localparam int unsigned ProdW = 66;
    localparam int unsigned QW    = 15;
    localparam logic [3:0] MulLast   = 4'd14;
    localparam logic [3:0] SqLast    = 4'd3;
    localparam logic [3:0] DivLast   = 4'(QW - 1);
    localparam logic [3:0] CrossLast = 4'd6;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_CLASS = 10'b0000000100,
        ST_LOAD  = 10'b0000001000,
        ST_SHIFT = 10'b0000010000,
        ST_SQ    = 10'b0000100000,
        ST_SQRT  = 10'b0001000000,
        ST_DIVLD = 10'b0010000000,
        ST_DIV   = 10'b0100000000,
        ST_CROSS = 10'b1000000000
    } state_t;

    state_t        state_reg;
    logic          done_reg;
    logic [3:0]    step_reg;
    logic          grp_reg;
    logic [1:0]    idx_reg;
    logic          cross_reg;
    logic          rvalid_reg;
    ttb_pkg::result_t rdata_reg;

    ttb_pkg::job_t job_reg;
    logic signed [WideW-1:0] acc_reg;
    logic signed [WideW-1:0] det_reg;
    logic signed [WideW-1:0] tvec_reg [3];
    logic signed [WideW-1:0] bvec_reg [3];
    logic [WideW-1:0] am_reg [3];
    logic             neg_reg [3];
    logic tz_reg, bz_reg, deg_reg;
    logic [61:0] sum_reg, x_reg, root_reg;
    logic [60:0] sq_bit_reg;
    logic [30:0] len_reg;
    logic [31:0] rem_reg;
    logic [QW-1:0] nlo_reg, quo_reg;
    ttb_pkg::outv_t tq_reg [3];
    ttb_pkg::outv_t bq_reg [3];

    logic signed [ttb_pkg::DeltaW-1:0] mul_a, mul_b;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [WideW-1:0] prod_ext, diff;
    logic [3:0] pc;
    logic [1:0] k;
    logic [WideW-1:0] orv;
    logic tz_now, bz_now;
    logic [61:0] sum_next, trial, root_next;
    logic [45:0] num;
    logic [32:0] rem_sh, dvs;
    logic        qbit;
    logic [QW-1:0] qf;
    ttb_pkg::outv_t src [3];

    assign job_ready = (state_reg == ST_IDLE) && !done_reg;
    assign res.valid = rvalid_reg;
    assign res.data  = rdata_reg;

    function automatic logic signed [ttb_pkg::DeltaW-1:0] ext16(ttb_pkg::outv_t x);
        return $signed({{(ttb_pkg::DeltaW - ttb_pkg::OutW){x[ttb_pkg::OutW-1]}}, x});
    endfunction

    function automatic ttb_pkg::outv_t round14(logic signed [WideW-1:0] x);
        logic [WideW-1:0] u;
        logic [WideW-1:0] q;
        u = x[WideW-1] ? WideW'(-x) : WideW'(x);
        q = (u + WideW'(8192)) >> 14;
        if (x[WideW-1])
        begin
            return (q > WideW'(32768)) ? 16'sh8000 : ttb_pkg::outv_t'(-q[15:0]);
        end
        return (q > WideW'(32767)) ? 16'sh7fff : ttb_pkg::outv_t'(q[15:0]);
    endfunction

    assign prod_ext = WideW'(prod_reg);
    assign diff     = acc_reg - prod_ext;
    assign pc       = step_reg - 4'd1;
    assign orv      = am_reg[0] | am_reg[1] | am_reg[2];
    assign tz_now   = (tvec_reg[0] == '0) && (tvec_reg[1] == '0) && (tvec_reg[2] == '0);
    assign bz_now   = (bvec_reg[0] == '0) && (bvec_reg[1] == '0) && (bvec_reg[2] == '0);
    assign sum_next = ((step_reg == 4'd1) ? 62'd0 : sum_reg) + 62'(prod_reg);
    assign trial    = root_reg + 62'(sq_bit_reg);
    assign root_next = (x_reg >= trial) ? ((root_reg >> 1) + 62'(sq_bit_reg))
                                        : (root_reg >> 1);
    assign num      = {1'b0, am_reg[idx_reg][29:0], {QW{1'b0}}} + 46'(len_reg);
    assign rem_sh   = {rem_reg, nlo_reg[QW-1]};
    assign dvs      = {1'b0, len_reg, 1'b0};
    assign qbit     = rem_sh >= dvs;
    assign qf       = {quo_reg[QW-2:0], qbit};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            src[i] = cross_reg ? tq_reg[i] : bq_reg[i];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        k     = 2'd0;
        unique case (state_reg)
            ST_MUL:
            begin
                priority if (step_reg == 4'd0)
                begin
                    mul_a = job_reg.d1u;
                    mul_b = job_reg.d2v;
                end
                else if (step_reg == 4'd1)
                begin
                    mul_a = job_reg.d2u;
                    mul_b = job_reg.d1v;
                end
                else if (step_reg < 4'd8)
                begin
                    k = 2'((step_reg - 4'd2) >> 1);
                    mul_a = step_reg[0] ? job_reg.d1v : job_reg.d2v;
                    mul_b = step_reg[0] ? job_reg.e2[k] : job_reg.e1[k];
                end
                else if (step_reg < MulLast)
                begin
                    k = 2'((step_reg - 4'd8) >> 1);
                    mul_a = step_reg[0] ? job_reg.d2u : job_reg.d1u;
                    mul_b = step_reg[0] ? job_reg.e1[k] : job_reg.e2[k];
                end
                else
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            end
            ST_SQ:
            begin
                if (step_reg < SqLast)
                begin
                    mul_a = $signed({3'b000, am_reg[step_reg[1:0]][29:0]});
                    mul_b = mul_a;
                end
            end
            ST_CROSS:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        mul_a = ext16(src[1]);
                        mul_b = ext16(job_reg.n[2]);
                    end
                    4'd1:
                    begin
                        mul_a = ext16(src[2]);
                        mul_b = ext16(job_reg.n[1]);
                    end
                    4'd2:
                    begin
                        mul_a = ext16(src[2]);
                        mul_b = ext16(job_reg.n[0]);
                    end
                    4'd3:
                    begin
                        mul_a = ext16(src[0]);
                        mul_b = ext16(job_reg.n[2]);
                    end
                    4'd4:
                    begin
                        mul_a = ext16(src[0]);
                        mul_b = ext16(job_reg.n[1]);
                    end
                    4'd5:
                    begin
                        mul_a = ext16(src[1]);
                        mul_b = ext16(job_reg.n[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            step_reg   <= 4'd0;
            grp_reg    <= 1'b0;
            idx_reg    <= 2'd0;
            cross_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (res.ready)
            begin
                rvalid_reg <= 1'b0;
            end
            if (done_reg && (!rvalid_reg || res.ready))
            begin
                rvalid_reg <= 1'b1;
                done_reg   <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid && !done_reg)
                    begin
                        state_reg <= ST_MUL;
                        step_reg  <= 4'd0;
                    end
                end
                ST_MUL:
                begin
                    if (step_reg == MulLast)
                    begin
                        state_reg <= ST_CLASS;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_CLASS:
                begin
                    priority if (det_reg == '0 || (tz_now && bz_now))
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else if (!tz_now)
                    begin
                        state_reg <= ST_LOAD;
                        grp_reg   <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ST_LOAD;
                        grp_reg   <= 1'b1;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT:
                begin
                    if (orv[WideW-1:30] == '0 && orv[29])
                    begin
                        state_reg <= ST_SQ;
                        step_reg  <= 4'd0;
                    end
                end
                ST_SQ:
                begin
                    if (step_reg == SqLast)
                    begin
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_bit_reg[0])
                    begin
                        state_reg <= ST_DIVLD;
                        idx_reg   <= 2'd0;
                    end
                end
                ST_DIVLD:
                begin
                    state_reg <= ST_DIV;
                    step_reg  <= 4'd0;
                end
                ST_DIV:
                begin
                    if (step_reg != DivLast)
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                    else if (idx_reg != 2'd2)
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_DIVLD;
                    end
                    else
                    begin
                        priority if (!grp_reg && !bz_reg)
                        begin
                            grp_reg   <= 1'b1;
                            state_reg <= ST_LOAD;
                        end
                        else if (tz_reg)
                        begin
                            cross_reg <= 1'b0;
                            step_reg  <= 4'd0;
                            state_reg <= ST_CROSS;
                        end
                        else if (bz_reg)
                        begin
                            cross_reg <= 1'b1;
                            step_reg  <= 4'd0;
                            state_reg <= ST_CROSS;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                            done_reg  <= 1'b1;
                        end
                    end
                end
                ST_CROSS:
                begin
                    if (step_reg != CrossLast)
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                    else if (!cross_reg && bz_reg)
                    begin
                        cross_reg <= 1'b1;
                        step_reg  <= 4'd0;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_reg && (!rvalid_reg || res.ready))
        begin
            rdata_reg.tangent_x   <= tq_reg[0];
            rdata_reg.tangent_y   <= tq_reg[1];
            rdata_reg.tangent_z   <= tq_reg[2];
            rdata_reg.bitangent_x <= bq_reg[0];
            rdata_reg.bitangent_y <= bq_reg[1];
            rdata_reg.bitangent_z <= bq_reg[2];
            rdata_reg.degenerate  <= deg_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && !done_reg)
                begin
                    job_reg <= job;
                    deg_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        tq_reg[i] <= '0;
                        bq_reg[i] <= '0;
                    end
                end
            end
            ST_MUL:
            begin
                if (step_reg != 4'd0)
                begin
                    if (!pc[0])
                    begin
                        acc_reg <= prod_ext;
                    end
                    else if (pc == 4'd1)
                    begin
                        det_reg <= diff;
                    end
                    else if (pc < 4'd8)
                    begin
                        tvec_reg[2'((pc - 4'd2) >> 1)] <= det_reg[WideW-1] ? -diff : diff;
                    end
                    else
                    begin
                        bvec_reg[2'((pc - 4'd8) >> 1)] <= det_reg[WideW-1] ? -diff : diff;
                    end
                end
            end
            ST_CLASS:
            begin
                deg_reg <= det_reg == '0;
                tz_reg  <= tz_now;
                bz_reg  <= bz_now;
            end
            ST_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= grp_reg ? bvec_reg[i][WideW-1] : tvec_reg[i][WideW-1];
                    am_reg[i]  <= grp_reg
                        ? (bvec_reg[i][WideW-1] ? WideW'(-bvec_reg[i]) : WideW'(bvec_reg[i]))
                        : (tvec_reg[i][WideW-1] ? WideW'(-tvec_reg[i]) : WideW'(tvec_reg[i]));
                end
            end
            ST_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    priority if (orv[WideW-1:38] != '0)
                    begin
                        am_reg[i] <= am_reg[i] >> 8;
                    end
                    else if (orv[WideW-1:30] != '0)
                    begin
                        am_reg[i] <= am_reg[i] >> 1;
                    end
                    else if (orv[WideW-1:21] == '0)
                    begin
                        am_reg[i] <= am_reg[i] << 8;
                    end
                    else if (!orv[29])
                    begin
                        am_reg[i] <= am_reg[i] << 1;
                    end
                    else
                    begin
                        am_reg[i] <= am_reg[i];
                    end
                end
            end
            ST_SQ:
            begin
                if (step_reg != 4'd0)
                begin
                    sum_reg <= sum_next;
                end
                if (step_reg == SqLast)
                begin
                    x_reg      <= sum_next;
                    root_reg   <= '0;
                    sq_bit_reg <= {1'b1, 60'd0};
                end
            end
            ST_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_reg <= x_reg - trial;
                end
                root_reg   <= root_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (sq_bit_reg[0])
                begin
                    len_reg <= root_next[30:0];
                end
            end
            ST_DIVLD:
            begin
                rem_reg <= 32'(num[45:QW]);
                nlo_reg <= num[QW-1:0];
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= qbit ? 32'(rem_sh - dvs) : rem_sh[31:0];
                nlo_reg <= nlo_reg << 1;
                quo_reg <= qf;
                if (step_reg == DivLast)
                begin
                    if (grp_reg)
                    begin
                        bq_reg[idx_reg] <= neg_reg[idx_reg] ? -$signed({1'b0, qf})
                                                            : $signed({1'b0, qf});
                    end
                    else
                    begin
                        tq_reg[idx_reg] <= neg_reg[idx_reg] ? -$signed({1'b0, qf})
                                                            : $signed({1'b0, qf});
                    end
                end
            end
            ST_CROSS:
            begin
                if (step_reg != 4'd0)
                begin
                    if (!pc[0])
                    begin
                        acc_reg <= prod_ext;
                    end
                    else if (cross_reg)
                    begin
                        bq_reg[2'(pc >> 1)] <= round14(diff);
                    end
                    else
                    begin
                        tq_reg[2'(pc >> 1)] <= round14(diff);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/triangle_tangent_bitangent.sv @@
// Top level of the triangle tangent and bitangent block.
// The vtx channel takes one vertex per beat, three beats per triangle, in order.
// After each third vertex one beat leaves on the res channel with the unit tangent
// and bitangent in Q2.14 and the degenerate flag; the first two vertices give none.
// The intake forms the edge and texture deltas in the cycle of the third beat and
// queues the triangle; a queue of FIFO_DEPTH triangles lets intake run ahead.
// The sequencer uses one shared 33 by 33 multiplier: first the products, then per
// nonzero vector scaling and squares, 31 square root steps and three divisions,
// and last each fallback cross product.
// A degenerate triangle leaves after the products, a full one waits on the bit
// serial square root and divider; one triangle is in the sequencer at a time.
// The result sits in an output register; while the receiver stalls the next
// triangle is still computed and then waits, and intake stalls once the queue fills.
// Reset clears the vertex slot, the queue and the output valid; no result is lost.
`default_nettype none
module triangle_tangent_bitangent #(
    parameter int unsigned FIFO_DEPTH = ttb_pkg::FifoDepth
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ttb_stream_if.sink  vtx,
    ttb_stream_if.source res
);

    ttb_pkg::job_t push_job;
    ttb_pkg::job_t pop_job;
    logic push_valid, push_ready, pop_valid, pop_ready;

    ttb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vtx        (vtx),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    ttb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    ttb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (pop_job),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .res       (res)
    );

endmodule
`default_nettype wire
